// File: rtl/core/mau_pkg.sv
package mau_pkg;

	localparam int WIDTH_DEF = 32;
	localparam int MOD_W     = 32;
	localparam int OPND_W    = 64;
	localparam int KIND_W    = 3;

	typedef enum logic [KIND_W-1:0] {
		OP_RED,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_INV,
		OP_POW,
		OP_NEG
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RED,
		ST_FIX,
		ST_OP,
		ST_MULW,
		ST_INV_TEST,
		ST_DIV,
		ST_TMUL,
		ST_INV_MUL,
		ST_POW_TEST,
		ST_POW_MR,
		ST_POW_SQ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [OPND_W-1:0] operand_a;
		logic signed [OPND_W-1:0] operand_b;
	} req_t;

	typedef struct packed {
		logic [MOD_W-1:0] result;
		logic             no_inverse;
	} rsp_t;

	function automatic logic [MOD_W:0] add_mod(input logic [MOD_W:0] p,
			input logic [MOD_W:0] q, input logic [MOD_W:0] m);
		logic [MOD_W:0] s;
		s = p + q;
		return (s >= m) ? s - m : s;
	endfunction

	function automatic logic [MOD_W:0] step_mod(input logic [MOD_W:0] r,
			input logic b, input logic [MOD_W:0] m);
		logic [MOD_W:0] s;
		s = {r[MOD_W-1:0], b};
		return (s >= m) ? s - m : s;
	endfunction

endpackage

// File: rtl/core/mau_mulmod.sv
module mau_mulmod #(
	parameter int WIDTH = mau_pkg::WIDTH_DEF,
	localparam int MW = (WIDTH < mau_pkg::MOD_W) ? WIDTH : mau_pkg::MOD_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [MW-1:0] x,
	input  logic [MW-1:0] y,
	input  logic [MW-1:0] m,
	output logic          done,
	output logic [MW-1:0] prod
);

	localparam int EW = mau_pkg::MOD_W + 1;
	localparam int CW = $clog2(MW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] acc_q;
	logic [MW-1:0] xs_q;
	logic [MW-1:0] ys_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(MW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// add the doubled multiplicand for each set multiplier bit, lsb first
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			xs_q  <= x;
			ys_q  <= y;
		end else if (busy_q) begin
			if (ys_q[0])
				acc_q <= MW'(mau_pkg::add_mod(EW'(acc_q), EW'(xs_q), EW'(m)));
			xs_q <= MW'(mau_pkg::add_mod(EW'(xs_q), EW'(xs_q), EW'(m)));
			ys_q <= ys_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// File: rtl/core/modular_arithmetic_unit.sv
// Modular ALU over a configured modulus, one result per request.
// Request channel req_valid/req_stall/req carries kind, operand_a and operand_b;
// response channel rsp_valid/rsp_stall/rsp carries result and no_inverse.
// The modulus is written through cfg_we/cfg_wdata; the user must write it
// only while the unit is idle, as the unit itself does not enforce this.
// The operand reduction takes one bit a cycle over all 64 operand bits;
// reduce/add/sub/negate then finish in ST_OP; multiply is bit-serial. Inverse
// runs extended Euclid, each step a bit-serial divide plus a modular multiply.
// Divide adds one inverse and one multiply. Power spends one multiply per
// exponent bit plus one more per set bit, over the exponent's bit length.
// A zero modulus answers zero with no work. One request is in work at a time;
// the next is taken while a finished response still waits in the output
// register. A stalled response holds; the unit then waits at its end.
// Reset sets the modulus to 2 and empties the unit.
module modular_arithmetic_unit #(
	parameter int WIDTH = mau_pkg::WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [mau_pkg::MOD_W-1:0]  cfg_wdata,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  mau_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output mau_pkg::rsp_t              rsp
);

	localparam int MW = (WIDTH < mau_pkg::MOD_W) ? WIDTH : mau_pkg::MOD_W;
	localparam int EW = mau_pkg::MOD_W + 1;
	localparam int OW = mau_pkg::OPND_W;
	localparam int CW = $clog2(OW);

	mau_pkg::state_t state_q, state_d;

	logic [mau_pkg::MOD_W-1:0]  mod_q;
	logic [MW-1:0]              m;
	logic [MW-1:0]              one_m;
	logic [mau_pkg::KIND_W-1:0] kind_q;
	logic                       nega_q, negb_q;
	logic [OW-1:0]              ma_q, mb_q, e_q;
	logic [OW-1:0]              raw_a, raw_b, mag_a, mag_b;
	logic [MW-1:0]              ra_q, rb_q, x_q, y_q, u_q, v_q;
	logic [MW-1:0]              base_q, pr_q, dq_q, quo_q, rem_q, res_q;
	logic                       bad_q;
	logic [CW-1:0]              cnt_q;
	logic                       rsp_valid_q;
	mau_pkg::rsp_t              rsp_q;

	logic [MW-1:0] fix_a, fix_b, sum_ab, diff_ab, neg_a, tred, tmp_u, rem_n;
	logic [MW:0]   rem2;
	logic          ge, inv_ok;

	logic          mul_start, mul_done;
	logic [MW-1:0] mul_x, mul_y, mul_p;

	assign m      = mod_q[MW-1:0];
	assign one_m  = (m == MW'(1)) ? '0 : MW'(1);
	assign raw_a  = req.operand_a;
	assign raw_b  = req.operand_b;
	assign mag_a  = raw_a[OW-1] ? OW'(~raw_a + 1'b1) : raw_a;
	assign mag_b  = raw_b[OW-1] ? OW'(~raw_b + 1'b1) : raw_b;
	assign fix_a  = (nega_q && ra_q != '0) ? MW'(m - ra_q) : ra_q;
	assign fix_b  = (negb_q && rb_q != '0) ? MW'(m - rb_q) : rb_q;
	assign sum_ab = MW'(mau_pkg::add_mod(EW'(ra_q), EW'(rb_q), EW'(m)));
	assign diff_ab = (ra_q >= rb_q) ? MW'(ra_q - rb_q) : MW'(ra_q - rb_q + m);
	assign neg_a  = (ra_q == '0) ? '0 : MW'(m - ra_q);
	assign tred   = (quo_q >= m) ? MW'(quo_q - m) : quo_q;
	assign tmp_u  = (u_q >= mul_p) ? MW'(u_q - mul_p) : MW'(u_q - mul_p + m);
	assign rem2   = {rem_q, dq_q[MW-1]};
	assign ge     = rem2 >= {1'b0, x_q};
	assign rem_n  = ge ? MW'(rem2 - {1'b0, x_q}) : rem2[MW-1:0];
	assign inv_ok = (y_q == MW'(1));

	mau_mulmod #(.WIDTH(WIDTH)) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.x      (mul_x),
		.y      (mul_y),
		.m      (m),
		.done   (mul_done),
		.prod   (mul_p)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			mau_pkg::ST_IDLE: begin
				if (req_valid)
					state_d = (m == '0) ? mau_pkg::ST_DONE : mau_pkg::ST_RED;
			end
			mau_pkg::ST_RED: begin
				if (cnt_q == '0)
					state_d = mau_pkg::ST_FIX;
			end
			mau_pkg::ST_FIX: state_d = mau_pkg::ST_OP;
			mau_pkg::ST_OP: begin
				case (mau_pkg::kind_t'(kind_q))
					mau_pkg::OP_MUL: state_d = mau_pkg::ST_MULW;
					mau_pkg::OP_DIV, mau_pkg::OP_INV: state_d = mau_pkg::ST_INV_TEST;
					mau_pkg::OP_POW:
						state_d = negb_q ? mau_pkg::ST_INV_TEST : mau_pkg::ST_POW_TEST;
					default: state_d = mau_pkg::ST_DONE;
				endcase
			end
			mau_pkg::ST_MULW: begin
				if (mul_done)
					state_d = mau_pkg::ST_DONE;
			end
			mau_pkg::ST_INV_TEST: begin
				if (x_q != '0)
					state_d = mau_pkg::ST_DIV;
				else if (!inv_ok)
					state_d = mau_pkg::ST_DONE;
				else begin
					case (mau_pkg::kind_t'(kind_q))
						mau_pkg::OP_DIV: state_d = mau_pkg::ST_MULW;
						mau_pkg::OP_POW: state_d = mau_pkg::ST_POW_TEST;
						default: state_d = mau_pkg::ST_DONE;
					endcase
				end
			end
			mau_pkg::ST_DIV: begin
				if (cnt_q == '0)
					state_d = mau_pkg::ST_TMUL;
			end
			mau_pkg::ST_TMUL: state_d = mau_pkg::ST_INV_MUL;
			mau_pkg::ST_INV_MUL: begin
				if (mul_done)
					state_d = mau_pkg::ST_INV_TEST;
			end
			mau_pkg::ST_POW_TEST: begin
				if (e_q == '0)
					state_d = mau_pkg::ST_DONE;
				else
					state_d = e_q[0] ? mau_pkg::ST_POW_MR : mau_pkg::ST_POW_SQ;
			end
			mau_pkg::ST_POW_MR: begin
				if (mul_done)
					state_d = mau_pkg::ST_POW_SQ;
			end
			mau_pkg::ST_POW_SQ: begin
				if (mul_done)
					state_d = mau_pkg::ST_POW_TEST;
			end
			mau_pkg::ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall)
					state_d = mau_pkg::ST_IDLE;
			end
			default: state_d = mau_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != mau_pkg::ST_IDLE);
		mul_start = 1'b0;
		mul_x     = ra_q;
		mul_y     = rb_q;
		case (state_q)
			mau_pkg::ST_OP: begin
				mul_start = (mau_pkg::kind_t'(kind_q) == mau_pkg::OP_MUL);
			end
			mau_pkg::ST_TMUL: begin
				mul_start = 1'b1;
				mul_x     = tred;
				mul_y     = v_q;
			end
			mau_pkg::ST_INV_TEST: begin
				mul_start = (x_q == '0) && inv_ok &&
					(mau_pkg::kind_t'(kind_q) == mau_pkg::OP_DIV);
				mul_y     = u_q;
			end
			mau_pkg::ST_POW_TEST: begin
				mul_start = (e_q != '0);
				mul_x     = e_q[0] ? pr_q : base_q;
				mul_y     = base_q;
			end
			mau_pkg::ST_POW_MR: begin
				mul_start = mul_done;
				mul_x     = base_q;
				mul_y     = base_q;
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mau_pkg::ST_IDLE;
			mod_q       <= mau_pkg::MOD_W'(2);
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				mod_q <= cfg_wdata;
			if (state_q == mau_pkg::ST_DONE && (!rsp_valid_q || !rsp_stall))
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mau_pkg::ST_DONE && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q.result     <= mau_pkg::MOD_W'(res_q);
			rsp_q.no_inverse <= bad_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mau_pkg::ST_IDLE: begin
				if (req_valid) begin
					kind_q <= req.kind;
					nega_q <= raw_a[OW-1];
					negb_q <= raw_b[OW-1];
					ma_q   <= mag_a;
					mb_q   <= mag_b;
					e_q    <= mag_b;
					ra_q   <= '0;
					rb_q   <= '0;
					cnt_q  <= CW'(OW - 1);
					res_q  <= '0;
					bad_q  <= 1'b0;
				end
			end
			mau_pkg::ST_RED: begin
				ra_q  <= MW'(mau_pkg::step_mod(EW'(ra_q), ma_q[OW-1], EW'(m)));
				rb_q  <= MW'(mau_pkg::step_mod(EW'(rb_q), mb_q[OW-1], EW'(m)));
				ma_q  <= ma_q << 1;
				mb_q  <= mb_q << 1;
				cnt_q <= cnt_q - 1'b1;
			end
			mau_pkg::ST_FIX: begin
				ra_q <= fix_a;
				rb_q <= fix_b;
			end
			mau_pkg::ST_OP: begin
				case (mau_pkg::kind_t'(kind_q))
					mau_pkg::OP_RED: res_q <= ra_q;
					mau_pkg::OP_ADD: res_q <= sum_ab;
					mau_pkg::OP_SUB: res_q <= diff_ab;
					mau_pkg::OP_NEG: res_q <= neg_a;
					mau_pkg::OP_DIV: begin
						x_q <= rb_q;
						y_q <= m;
						u_q <= '0;
						v_q <= one_m;
					end
					mau_pkg::OP_INV: begin
						x_q <= ra_q;
						y_q <= m;
						u_q <= '0;
						v_q <= one_m;
					end
					mau_pkg::OP_POW: begin
						x_q    <= ra_q;
						y_q    <= m;
						u_q    <= '0;
						v_q    <= one_m;
						base_q <= ra_q;
						pr_q   <= one_m;
					end
					default: res_q <= res_q;
				endcase
			end
			mau_pkg::ST_MULW: begin
				if (mul_done)
					res_q <= mul_p;
			end
			mau_pkg::ST_INV_TEST: begin
				if (x_q != '0) begin
					dq_q  <= y_q;
					rem_q <= '0;
					cnt_q <= CW'(MW - 1);
				end else if (!inv_ok) begin
					bad_q <= 1'b1;
				end else begin
					case (mau_pkg::kind_t'(kind_q))
						mau_pkg::OP_INV: res_q <= u_q;
						mau_pkg::OP_POW: begin
							base_q <= u_q;
							pr_q   <= one_m;
						end
						default: res_q <= res_q;
					endcase
				end
			end
			mau_pkg::ST_DIV: begin
				rem_q <= rem_n;
				dq_q  <= dq_q << 1;
				quo_q <= {quo_q[MW-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
			end
			mau_pkg::ST_TMUL: begin
				y_q <= x_q;
				x_q <= rem_q;
			end
			mau_pkg::ST_INV_MUL: begin
				if (mul_done) begin
					u_q <= v_q;
					v_q <= tmp_u;
				end
			end
			mau_pkg::ST_POW_TEST: begin
				if (e_q == '0)
					res_q <= pr_q;
			end
			mau_pkg::ST_POW_MR: begin
				if (mul_done)
					pr_q <= mul_p;
			end
			mau_pkg::ST_POW_SQ: begin
				if (mul_done) begin
					base_q <= mul_p;
					e_q    <= e_q >> 1;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
